@@ sv/mdt_pkg.sv @@
package mdt_pkg;

  localparam int unsigned SLOTS   = 4;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned SLOT_CW = $clog2(SLOTS + 1) + 1;
  localparam int unsigned VAL_W   = 32;

  localparam logic KIND_EXPIRE = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ARM_REL  = 3'd1,
    OP_ARM_ABS  = 3'd2,
    OP_CANCEL   = 3'd3,
    OP_SET_PER  = 3'd4,
    OP_NUDGE    = 3'd5,
    OP_TRANSFER = 3'd6,
    OP_UNUSED   = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] target_slot;
    logic [VAL_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] fired_slot;
    logic              accepted;
    logic              last;
  } out_beat_t;

  // Per-cell command from the controller.
  typedef struct packed {
    logic             set_act;
    logic             clr_act;
    logic             wr_dl;
    logic [VAL_W-1:0] dl;
  } cell_cmd_t;

endpackage

@@ sv/mdt_cell.sv @@
module mdt_cell import mdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [VAL_W-1:0] time_i,
  input  cell_cmd_t        cmd_i,
  input  logic             skip_i,
  input  logic             adv_i,
  input  logic             tok_i,
  input  logic             tail_i,
  output logic             tok_o,
  output logic             tail_o,
  output logic             fire_o,
  output logic             fire_last_o
);

  logic             active_q, active_d;
  logic [VAL_W-1:0] deadline_q, deadline_d;
  logic             tok_q, tok_d;
  logic [VAL_W-1:0] diff;
  logic             due;

  assign diff = time_i - deadline_q;
  assign due  = active_q && !skip_i && !diff[VAL_W-1];

  assign fire_o      = tok_q && due;
  assign fire_last_o = fire_o && !tail_i;
  assign tail_o      = due || tail_i;
  assign tok_o       = tok_q;

  always_comb begin
    active_d   = active_q;
    deadline_d = deadline_q;
    tok_d      = tok_q;
    if (cmd_i.wr_dl) begin
      deadline_d = cmd_i.dl;
    end
    if (cmd_i.set_act) begin
      active_d = 1'b1;
    end else if (cmd_i.clr_act || (fire_o && adv_i)) begin
      active_d = 1'b0;
    end
    // pass the scan token one cell down
    if (adv_i) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      deadline_q <= '0;
      tok_q      <= 1'b0;
    end else begin
      active_q   <= active_d;
      deadline_q <= deadline_d;
      tok_q      <= tok_d;
    end
  end

endmodule

@@ sv/multi_slot_deadline_timer_top.sv @@
// Channel   Signals                                   Beat
// in        in_valid_i  / in_ready_o  / in_data_i     one command or tick
// out       out_valid_o / out_ready_i / out_data_o    one expiry event or ack
//
// A command other than OP_UNUSED loads its ack into the output register.
// A tick that ends a cycle or runs in one-shot mode starts a scan token down
// the row of slot cells, in periodic mode after the owner event; the token
// then moves one cell down per step. Other ticks only advance the counts.
// Reset clears all slots, the time count and periodic mode.
// A stalled output holds the token at a firing cell; no input is taken until the scan ends.
module multi_slot_deadline_timer_top import mdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_OWNER = 3'b010,
    ST_SCAN  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [VAL_W-1:0]  time_q, time_d;
  logic              per_q, per_d;
  logic [SLOT_W-1:0] owner_q, owner_d;
  logic [VAL_W-1:0]  period_q, period_d;
  logic [VAL_W-1:0]  cnt_q, cnt_d;
  logic [VAL_W-1:0]  sreq_q, sreq_d;
  logic [VAL_W-1:0]  sapp_q, sapp_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  cell_cmd_t         cmd [SLOTS];
  logic [SLOTS-1:0]  skip, tok, tail, fire, fire_last;
  logic              adv, start, scan_adv, any_fire, fire_last_any;
  logic [SLOT_W-1:0] fire_idx;

  logic              out_free, accept, s_ok, t_ok, is_owner;
  logic [VAL_W:0]    len_sum, cnt_inc;
  logic [VAL_W-1:0]  len;
  logic              boundary;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign s_ok     = SLOT_CW'(in_data_i.slot) < SLOT_CW'(SLOTS);
  assign t_ok     = SLOT_CW'(in_data_i.target_slot) < SLOT_CW'(SLOTS);
  assign is_owner = per_q && (owner_q == in_data_i.slot);

  // saturating cycle length and boundary test
  assign len_sum  = {1'b0, period_q} + {1'b0, sapp_q};
  assign len      = len_sum[VAL_W] ? '1 : len_sum[VAL_W-1:0];
  assign cnt_inc  = {1'b0, cnt_q} + (VAL_W+1)'(1);
  assign boundary = cnt_inc >= {1'b0, len};

  // row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic tok_in, tail_in;
    if (i == 0) begin : g_head
      assign tok_in = start;
    end else begin : g_body
      assign tok_in = tok[i-1];
    end
    if (i == SLOTS - 1) begin : g_end
      assign tail_in = 1'b0;
    end else begin : g_mid
      assign tail_in = tail[i+1];
    end
    assign skip[i] = per_q && (int'(owner_q) == i);

    mdt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .time_i      (time_q),
      .cmd_i       (cmd[i]),
      .skip_i      (skip[i]),
      .adv_i       (adv),
      .tok_i       (tok_in),
      .tail_i      (tail_in),
      .tok_o       (tok[i]),
      .tail_o      (tail[i]),
      .fire_o      (fire[i]),
      .fire_last_o (fire_last[i])
    );
  end

  assign any_fire      = |fire;
  assign fire_last_any = |fire_last;
  assign scan_adv      = (state_q == ST_SCAN) && (!any_fire || out_free);
  assign adv           = start || scan_adv;

  always_comb begin
    fire_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (fire[i]) begin
        fire_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    per_d       = per_q;
    owner_d     = owner_q;
    period_d    = period_q;
    cnt_d       = cnt_q;
    sreq_d      = sreq_q;
    sapp_d      = sapp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    start       = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      cmd[i] = '0;
      cmd[i].dl = in_data_i.value;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.op == OP_TICK) begin
            time_d = time_q + VAL_W'(1);
            if (!per_q) begin
              start   = 1'b1;
              state_d = ST_SCAN;
            end else if (!boundary) begin
              cnt_d = cnt_inc[VAL_W-1:0];
            end else begin
              cnt_d  = '0;
              sapp_d = sreq_q;
              sreq_d = '0;
              state_d = ST_OWNER;
            end
          end else if (in_data_i.op != OP_UNUSED) begin
            out_valid_d    = 1'b1;
            out_d.kind     = KIND_ACK;
            out_d.fired_slot = in_data_i.slot;
            out_d.accepted = 1'b0;
            out_d.last     = 1'b1;
            if (s_ok) begin
              case (in_data_i.op)
                OP_ARM_REL, OP_ARM_ABS: begin
                  if (is_owner) begin
                    per_d  = 1'b0;
                    sreq_d = '0;
                    sapp_d = '0;
                    cnt_d  = '0;
                  end
                  for (int i = 0; i < SLOTS; i++) begin
                    if (int'(in_data_i.slot) == i) begin
                      cmd[i].wr_dl   = 1'b1;
                      cmd[i].set_act = 1'b1;
                      cmd[i].dl      = (in_data_i.op == OP_ARM_REL) ?
                                       time_q + in_data_i.value : in_data_i.value;
                    end
                  end
                end
                OP_CANCEL: begin
                  if (is_owner) begin
                    per_d  = 1'b0;
                    sreq_d = '0;
                    sapp_d = '0;
                    cnt_d  = '0;
                  end
                  for (int i = 0; i < SLOTS; i++) begin
                    if (int'(in_data_i.slot) == i) begin
                      cmd[i].clr_act = 1'b1;
                    end
                  end
                end
                OP_SET_PER: begin
                  for (int i = 0; i < SLOTS; i++) begin
                    if (per_q && owner_q != in_data_i.slot && int'(owner_q) == i) begin
                      cmd[i].clr_act = 1'b1;
                    end
                    if (int'(in_data_i.slot) == i) begin
                      cmd[i].set_act = 1'b1;
                    end
                  end
                  period_d = in_data_i.value;
                  per_d    = 1'b1;
                  owner_d  = in_data_i.slot;
                  cnt_d    = '0;
                  sreq_d   = '0;
                  sapp_d   = '0;
                end
                OP_NUDGE: begin
                  if (per_q && sreq_q == '0 && in_data_i.value != '0) begin
                    sreq_d         = in_data_i.value;
                    out_d.accepted = 1'b1;
                  end
                end
                OP_TRANSFER: begin
                  if (t_ok && is_owner) begin
                    for (int i = 0; i < SLOTS; i++) begin
                      if (int'(in_data_i.slot) == i &&
                          in_data_i.slot != in_data_i.target_slot) begin
                        cmd[i].clr_act = 1'b1;
                      end
                      if (int'(in_data_i.target_slot) == i) begin
                        cmd[i].set_act = 1'b1;
                      end
                    end
                    owner_d        = in_data_i.target_slot;
                    out_d.accepted = 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      ST_OWNER: begin
        // owner event first, then drain the other slots
        if (!skip[owner_q]) begin
          start   = 1'b1;
          state_d = ST_SCAN;
        end else if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_EXPIRE;
          out_d.fired_slot = owner_q;
          out_d.accepted   = 1'b0;
          out_d.last       = !tail[0];
          start            = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_adv) begin
          if (any_fire) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_EXPIRE;
            out_d.fired_slot = fire_idx;
            out_d.accepted   = 1'b0;
            out_d.last       = fire_last_any;
          end
          if (tok[SLOTS-1]) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      per_q       <= 1'b0;
      owner_q     <= '0;
      period_q    <= '0;
      cnt_q       <= '0;
      sreq_q      <= '0;
      sapp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      per_q       <= per_d;
      owner_q     <= owner_d;
      period_q    <= period_d;
      cnt_q       <= cnt_d;
      sreq_q      <= sreq_d;
      sapp_q      <= sapp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
